FILE: rtl/scm_pkg.sv
`timescale 1ns / 1ps
// Shared constants, item types and controller states of the stereo correlation meter.
package scm_pkg;

	// Field widths.
	localparam int SAMPLE_W = 16;
	localparam int PROD_W   = 32;
	localparam int WIN_W    = 48;
	localparam int CUM_W    = 64;
	localparam int CNT_W    = 32;
	localparam int WIDTH_W  = 14;

	// Length of the moving window, in products.
	localparam int WINDOW_LEN = 48000;
	localparam int RING_AW    = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

	// Serial multiplier: one multiplier bit per cycle.
	localparam int MUL_STEPS = SAMPLE_W;
	localparam int MUL_CW    = $clog2(MUL_STEPS);

	// Serial divider: one quotient bit per cycle.
	localparam int DIV_NUM_W = CUM_W;
	localparam int DIV_DEN_W = CNT_W;
	localparam int DIV_CW    = $clog2(DIV_NUM_W);

	// Width scaling: (1.0 - mean) * 5000 / 2^30 in hundredths.
	localparam int                   Q30_SHIFT   = 30;
	localparam int                   WPROD_W     = 45;
	localparam logic [12:0]          WIDTH_SCALE = 13'd5000;
	localparam logic [WIDTH_W:0]     WIDTH_MAX   = 15'd10000;
	localparam logic signed [32:0]   ONE_Q30     = 33'sd1073741824;
	localparam logic [CNT_W-1:0]     COUNT_MAX   = '1;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left_sample;
		logic signed [SAMPLE_W-1:0] right_sample;
	} pair_t;

	typedef struct packed {
		logic signed [PROD_W-1:0] instant_product;
		logic signed [PROD_W-1:0] window_average;
		logic signed [PROD_W-1:0] running_average;
		logic [WIDTH_W-1:0]       width_hundredths;
	} result_t;

	// Request to a serial divider: a sign and a magnitude over an unsigned divisor.
	typedef struct packed {
		logic                 start;
		logic                 neg;
		logic [DIV_NUM_W-1:0] mag;
		logic [DIV_DEN_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                     busy;
		logic signed [PROD_W-1:0] quotient;
	} div_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_UPDATE,
		ST_ACCUM,
		ST_DSTART,
		ST_DWAIT,
		ST_WIDTH,
		ST_FINISH
	} state_t;

endpackage

FILE: rtl/scm_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for sample pairs and meter results.
interface scm_pair_if;
	import scm_pkg::*;
	logic  valid;
	logic  ready;
	pair_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface scm_result_if;
	import scm_pkg::*;
	logic    valid;
	logic    ready;
	result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/scm_divider.sv
`timescale 1ns / 1ps
// Restoring divider that produces one quotient bit per cycle with a signed result.
module scm_divider (
	input  logic             clk,
	input  logic             arst_n,
	input  scm_pkg::div_req_t req,
	output scm_pkg::div_rsp_t rsp
);
	import scm_pkg::*;

	localparam logic [DIV_CW-1:0] LAST_STEP = DIV_CW'(DIV_NUM_W - 1);

	logic                     busy_q;
	logic [DIV_CW-1:0]        cnt_q;
	logic [DIV_NUM_W-1:0]     num_q;
	logic [DIV_DEN_W-1:0]     rem_q;
	logic [DIV_DEN_W-1:0]     den_q;
	logic                     neg_q;
	logic signed [PROD_W-1:0] quotient_q;

	logic [DIV_DEN_W:0]   shifted;
	logic [DIV_DEN_W:0]   trial;
	logic                 fits;
	logic [DIV_DEN_W-1:0] rem_next;
	logic [DIV_NUM_W-1:0] num_next;

	// The partial remainder always stays below the divisor, so one extra bit suffices.
	assign shifted  = {rem_q, num_q[DIV_NUM_W-1]};
	assign fits     = shifted >= {1'b0, den_q};
	assign trial    = shifted - {1'b0, den_q};
	assign rem_next = fits ? trial[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
	assign num_next = {num_q[DIV_NUM_W-2:0], fits};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == LAST_STEP) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.mag;
			rem_q <= '0;
			den_q <= req.divisor;
			neg_q <= req.neg;
		end else if (busy_q) begin
			num_q <= num_next;
			rem_q <= rem_next;
			if (cnt_q == LAST_STEP) begin
				// Negating the magnitude quotient truncates toward zero.
				quotient_q <= neg_q ? -$signed(num_next[PROD_W-1:0])
				                    : $signed(num_next[PROD_W-1:0]);
			end
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.quotient = quotient_q;

endmodule

FILE: rtl/stereo_correlation_meter.sv
`timescale 1ns / 1ps
// Top level of the stereo correlation meter with window and running averages.
//
//   Channel   Direction   Payload                                         Handshake
//   pair      in          left_sample, right_sample (signed Q1.15)        valid/ready
//   result    out         instant_product, window_average,                valid/ready
//                         running_average (Q2.30), width_hundredths
//
// An item is taken in the idle state and then passes through the bit-serial multiplier, the
// ring and accumulator update, the two bit-serial dividers running side by side, and the
// width scaling, before the meter can take the next one. The 64-step restoring dividers
// are the longest of these steps.
// The result sits in an output register, so a new item is taken while the previous result
// still waits for the sink; a result only holds the meter in its last step while the output
// register is still occupied.
// Reset is asynchronous and clears the controller, the totals and the count. The ring memory
// is not cleared: until the write position first wraps, an old entry reads as zero.
module stereo_correlation_meter (
	input  logic              clk,
	input  logic              arst_n,
	scm_pair_if.sink          pair,
	scm_result_if.source      result
);
	import scm_pkg::*;

	localparam logic [RING_AW-1:0] RING_LAST = RING_AW'(WINDOW_LEN - 1);
	localparam logic [MUL_CW-1:0]  MUL_LAST  = MUL_CW'(MUL_STEPS - 1);

	state_t state_q;
	state_t state_d;

	// Handshake and step controls, decoded from the state.
	logic accept;
	logic in_ready;
	logic ring_re;
	logic ring_we;
	logic div_start;
	logic out_load;

	// Serial multiplier: the multiplicand shifts left, the multiplier shifts right.
	logic [PROD_W-1:0]   mcand_q;
	logic [SAMPLE_W-1:0] mplier_q;
	logic [PROD_W-1:0]   acc_q;
	logic [MUL_CW-1:0]   mul_cnt_q;
	logic                prod_neg_q;
	logic [SAMPLE_W-1:0] left_mag;
	logic [SAMPLE_W-1:0] right_mag;

	logic signed [PROD_W-1:0] product_q;

	// Ring of products and the position that is overwritten next.
	logic [PROD_W-1:0]        ring_mem [WINDOW_LEN];
	logic [PROD_W-1:0]        ring_rd_q;
	logic [RING_AW-1:0]       ring_pos_q;
	logic                     wrapped_q;
	logic signed [PROD_W-1:0] old_prod;

	logic signed [WIN_W-1:0] window_total_q;
	logic signed [CUM_W-1:0] cum_total_q;
	logic [CNT_W-1:0]        count_q;

	// Divider requests and responses.
	logic signed [CUM_W-1:0] win_ext;
	div_req_t                win_req;
	div_req_t                run_req;
	div_rsp_t                win_rsp;
	div_rsp_t                run_rsp;

	// Width scaling.
	logic signed [32:0]   width_diff;
	logic [WPROD_W-1:0]   width_prod_s1;
	logic [WIDTH_W:0]     width_raw;
	logic [WIDTH_W-1:0]   width_val;

	logic    out_valid_q;
	result_t out_data_q;

	// Controller.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		ring_we   = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (pair.valid) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				if (mul_cnt_q == MUL_LAST) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				state_d = ST_ACCUM;
			end
			ST_ACCUM: begin
				ring_we = 1'b1;
				state_d = ST_DSTART;
			end
			ST_DSTART: begin
				div_start = 1'b1;
				state_d   = ST_DWAIT;
			end
			ST_DWAIT: begin
				if (!win_rsp.busy && !run_rsp.busy) begin
					state_d = ST_WIDTH;
				end
			end
			ST_WIDTH: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				// The result leaves only when the output register is free or being emptied.
				if (!out_valid_q || result.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign accept     = in_ready && pair.valid;
	assign ring_re    = accept;
	assign pair.ready = in_ready;

	// Sign and magnitude of each sample; the magnitude of -1.0 is 2^15 and still fits.
	assign left_mag  = pair.data.left_sample[SAMPLE_W-1]
	                   ? SAMPLE_W'(-pair.data.left_sample)
	                   : SAMPLE_W'(pair.data.left_sample);
	assign right_mag = pair.data.right_sample[SAMPLE_W-1]
	                   ? SAMPLE_W'(-pair.data.right_sample)
	                   : SAMPLE_W'(pair.data.right_sample);

	always_ff @(posedge clk) begin
		if (accept) begin
			mcand_q    <= PROD_W'(left_mag);
			mplier_q   <= right_mag;
			acc_q      <= '0;
			mul_cnt_q  <= '0;
			prod_neg_q <= pair.data.left_sample[SAMPLE_W-1] ^ pair.data.right_sample[SAMPLE_W-1];
		end else if (state_q == ST_MUL) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q   <= {mcand_q[PROD_W-2:0], 1'b0};
			mplier_q  <= {1'b0, mplier_q[SAMPLE_W-1:1]};
			mul_cnt_q <= mul_cnt_q + 1'b1;
		end
		if (state_q == ST_UPDATE) begin
			product_q <= prod_neg_q ? -$signed(acc_q) : $signed(acc_q);
		end
	end

	// Ring memory: the entry about to be replaced is read when the item is accepted and
	// written back with the new product in the accumulate state, after the update state.
	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_mem[ring_pos_q] <= product_q;
		end
		if (ring_re) begin
			ring_rd_q <= ring_mem[ring_pos_q];
		end
	end

	// Before the first wrap the old entry is taken as zero, since reset does not clear the ring.
	assign old_prod = wrapped_q ? $signed(ring_rd_q) : '0;

	// The totals and the count belong to the meter's state and are cleared by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_pos_q     <= '0;
			wrapped_q      <= 1'b0;
			window_total_q <= '0;
			cum_total_q    <= '0;
			count_q        <= '0;
		end else if (ring_we) begin
			window_total_q <= window_total_q - WIN_W'(old_prod) + WIN_W'(product_q);
			if (ring_pos_q == RING_LAST) begin
				ring_pos_q <= '0;
				wrapped_q  <= 1'b1;
			end else begin
				ring_pos_q <= ring_pos_q + 1'b1;
			end
			// Once the count saturates the running average stays frozen.
			if (count_q != COUNT_MAX) begin
				cum_total_q <= cum_total_q + CUM_W'(product_q);
				count_q     <= count_q + 1'b1;
			end
		end
	end

	// Both averages divide a magnitude and restore the sign afterward, which truncates
	// toward zero. The count is at least one whenever a division starts.
	assign win_ext = CUM_W'(window_total_q);

	assign win_req.start   = div_start;
	assign win_req.neg     = window_total_q[WIN_W-1];
	assign win_req.mag     = win_ext[CUM_W-1] ? DIV_NUM_W'(-win_ext) : DIV_NUM_W'(win_ext);
	assign win_req.divisor = DIV_DEN_W'(WINDOW_LEN);

	assign run_req.start   = div_start;
	assign run_req.neg     = cum_total_q[CUM_W-1];
	assign run_req.mag     = cum_total_q[CUM_W-1] ? DIV_NUM_W'(-cum_total_q)
	                                              : DIV_NUM_W'(cum_total_q);
	assign run_req.divisor = count_q;

	scm_divider u_win_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (win_req),
		.rsp    (win_rsp)
	);

	scm_divider u_run_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (run_req),
		.rsp    (run_rsp)
	);

	// Width = (1.0 - running mean) * 5000 / 2^30. The running mean lies within +/-1.0, so
	// the difference lies in 0 to 2^31 and the scaled value never exceeds 10000.
	assign width_diff = ONE_Q30 - 33'(run_rsp.quotient);

	always_ff @(posedge clk) begin
		if (state_q == ST_WIDTH) begin
			width_prod_s1 <= {13'd0, width_diff[31:0]} * {32'd0, WIDTH_SCALE};
		end
	end

	assign width_raw = width_prod_s1[WPROD_W-1:Q30_SHIFT];
	assign width_val = (width_raw > WIDTH_MAX) ? WIDTH_W'(WIDTH_MAX) : width_raw[WIDTH_W-1:0];

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q.instant_product  <= product_q;
			out_data_q.window_average   <= win_rsp.quotient;
			out_data_q.running_average  <= run_rsp.quotient;
			out_data_q.width_hundredths <= width_val;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_data_q;

endmodule

FILE: rtl/scm_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the stereo correlation meter and their binding to the top level.
module scm_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             pair_valid,
	input logic             pair_ready,
	input logic             result_valid,
	input logic             result_ready,
	input scm_pkg::result_t result_data
);
	import scm_pkg::*;

	// A waiting result is not withdrawn.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result withdrawn while stalled");

	// A waiting result does not change.
	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(result_data))
		else $error("result changed while stalled");

	// The meter works on one item at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		pair_valid && pair_ready |=> !pair_ready)
		else $error("pair taken while an item is in work");

	// The width never leaves its range.
	a_width_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result_data.width_hundredths <= WIDTH_W'(10000))
		else $error("width out of range");

	// A product of two Q1.15 samples stays within +/-1.0 in Q2.30.
	a_product_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result_data.instant_product <= 32'sd1073741824) &&
		                 (result_data.instant_product >= -32'sd1073741824))
		else $error("product out of range");

endmodule

bind stereo_correlation_meter scm_checker u_scm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.pair_valid   (pair.valid),
	.pair_ready   (pair.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.result_data  (result.data)
);

FILE: sim/stereo_correlation_meter_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of the stereo correlation meter with a built-in predictor.
module stereo_correlation_meter_test;
	import scm_pkg::*;

	// Sixteen directed pairs come first, and random pairs make up the rest of the run.
	localparam int DIRECTED_ITEMS = 16;
	localparam int TOTAL_ITEMS    = 1950;

	// The run is split into four idling phases of nearly equal length, counted in items.
	localparam int PHASE_LEN = (TOTAL_ITEMS + 3) / 4;

	// The long hold-off of the result sink starts after this many results have been taken.
	localparam int HOLD_AT     = 40;
	localparam int HOLD_CYCLES = 600;

	// The drain after the last expected reading lets a stray reading still be caught.
	localparam int DRAIN_CYCLES = 200;
	localparam int CYCLE_LIMIT  = 2_000_000;

	localparam longint Q30_ONE       = 64'sd1073741824;
	localparam longint COUNT_CEILING = 64'sd4294967295;
	localparam longint WIDTH_CAP     = 64'sd10000;

	typedef enum int {
		PHASE_FREE,
		PHASE_SOURCE_GAPS,
		PHASE_SINK_STALLS,
		PHASE_BOTH_LIGHT
	} idle_phase_e;

	typedef enum int {
		SPREAD_RANDOM,
		IN_PHASE,
		OUT_OF_PHASE,
		RAIL_VALUES,
		QUIET
	} stim_mode_e;

	// Directed pairs, left sample in the upper half of each word. They cover zero, both
	// full-scale rails in every combination, the largest product (-1.0 times -1.0), the
	// smallest nonzero magnitudes, half scale, and alternating bit patterns.
	logic [31:0] directed_words [DIRECTED_ITEMS] = '{
		32'h0000_0000, 32'h7FFF_7FFF, 32'h8000_8000, 32'h8000_7FFF,
		32'h7FFF_8000, 32'hFFFF_FFFF, 32'h0001_0001, 32'hFFFF_0001,
		32'h0001_8000, 32'h8000_0001, 32'h4000_4000, 32'hC000_4000,
		32'h5555_AAAA, 32'hAAAA_5555, 32'h7FFF_0000, 32'h0000_8000
	};
	logic [15:0] rail_values [5] = '{16'h8000, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF};

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// The channel inputs come from registers with known start values, so nothing the meter
	// sees is ever unknown, even before the first clock edge.
	logic  offer_valid = 1'b0;
	pair_t offer_data  = '0;
	logic  take_ready  = 1'b0;

	scm_pair_if   pair_ch ();
	scm_result_if result_ch ();

	assign pair_ch.valid   = offer_valid;
	assign pair_ch.data    = offer_data;
	assign result_ch.ready = take_ready;

	stereo_correlation_meter u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pair   (pair_ch),
		.result (result_ch)
	);

	always #5 clk = ~clk;

	// Pairs waiting to be offered, and readings the meter still owes, oldest first. Each
	// list is an array with a read and a write index.
	pair_t   pending_pairs [TOTAL_ITEMS];
	int      pend_rd = 0;
	int      pend_wr = 0;
	result_t expected_readings [TOTAL_ITEMS];
	int      exp_rd = 0;
	int      exp_wr = 0;

	int sent_count = 0;
	int recv_count = 0;
	int failures   = 0;
	int cycle_count = 0;
	int hold_left  = 0;
	bit hold_done  = 1'b0;

	// Mirror of the meter's state. The ring holds Q2.30 products, the window sum covers the
	// whole ring, and the cumulative sum and count stop moving once the count saturates.
	// The run stays far below the ring length, so the write position never wraps here.
	int     ring_products [WINDOW_LEN];
	int     ring_pos     = 0;
	longint window_sum   = 0;
	longint total_sum    = 0;
	longint total_count  = 0;

	// Works out the reading that one accepted pair produces and advances the mirrored state.
	// SystemVerilog division of signed integers truncates toward zero, as the meter does.
	function automatic result_t predict_reading(pair_t p);
		longint  prod;
		longint  win_avg;
		longint  run_avg;
		longint  width;
		result_t reading;
		prod = longint'(p.left_sample) * longint'(p.right_sample);
		window_sum = window_sum - longint'(ring_products[ring_pos]) + prod;
		ring_products[ring_pos] = int'(prod);
		ring_pos = (ring_pos + 1 >= WINDOW_LEN) ? 0 : ring_pos + 1;
		win_avg = window_sum / longint'(WINDOW_LEN);
		if (total_count < COUNT_CEILING) begin
			total_sum   = total_sum + prod;
			total_count = total_count + 1;
		end
		run_avg = (total_count != 0) ? total_sum / total_count : 64'sd0;
		// The running mean lies in [-1.0, +1.0], so the distance from +1.0 is at most 2^31
		// and the scaled value fits easily in 64 bits.
		width = ((Q30_ONE - run_avg) * 5000) >>> 30;
		if (width > WIDTH_CAP)
			width = WIDTH_CAP;
		reading.instant_product  = prod[31:0];
		reading.window_average   = win_avg[31:0];
		reading.running_average  = run_avg[31:0];
		reading.width_hundredths = width[13:0];
		return reading;
	endfunction

	function automatic idle_phase_e phase_of(int n);
		return idle_phase_e'((n / PHASE_LEN) % 4);
	endfunction

	// Percentage of cycles in which one side idles, for the given phase and side.
	function automatic int idle_pct(idle_phase_e phase, bit sink_side);
		case (phase)
			PHASE_SOURCE_GAPS: return sink_side ? 0 : 50;
			PHASE_SINK_STALLS: return sink_side ? 50 : 0;
			PHASE_BOTH_LIGHT: return 8;
			default: return 0;
		endcase
	endfunction

	task automatic compare_field(string field_name, longint want, longint got);
		if (want != got) begin
			$display("%0t ns: %s mismatch on reading %0d: expected %0d, got %0d",
				$time, field_name, recv_count, want, got);
			failures++;
		end
	endtask

	task automatic check_reading(result_t got);
		result_t want;
		if (exp_rd == exp_wr) begin
			$display("%0t ns: unexpected reading: expected none, got %h", $time, got);
			failures++;
		end else begin
			want = expected_readings[exp_rd];
			exp_rd++;
			compare_field("instant_product", want.instant_product, got.instant_product);
			compare_field("window_average", want.window_average, got.window_average);
			compare_field("running_average", want.running_average, got.running_average);
			compare_field("width_hundredths", want.width_hundredths, got.width_hundredths);
		end
	endtask

	// Pair driver. The prediction is made at the edge where the meter takes the pair, and a
	// new pair is offered only when the current one has gone or none is on offer.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offer_valid <= 1'b0;
			offer_data  <= '0;
		end else begin
			if (pair_ch.valid && pair_ch.ready) begin
				expected_readings[exp_wr] = predict_reading(pair_ch.data);
				exp_wr++;
				sent_count++;
			end
			if (!pair_ch.valid || pair_ch.ready) begin
				if (pend_rd < pend_wr &&
				    $urandom_range(99) >= idle_pct(phase_of(sent_count), 1'b0)) begin
					offer_valid <= 1'b1;
					offer_data  <= pending_pairs[pend_rd];
					pend_rd++;
				end else begin
					offer_valid <= 1'b0;
				end
			end
		end
	end

	// Long hold-off of the result sink, counted here in cycles. It starts once, after the
	// first few readings, while the driver keeps offering pairs.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && recv_count >= HOLD_AT) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
		end
	end

	// Reading monitor. Besides the random stalls of each phase it keeps ready low during the
	// long hold-off, so the output register fills and the meter has to stall its input side.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			take_ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				check_reading(result_ch.data);
				recv_count++;
			end
			if (hold_left > 0) begin
				take_ready <= 1'b0;
			end else begin
				take_ready <= ($urandom_range(99) >= idle_pct(phase_of(recv_count), 1'b1));
			end
		end
	end

	// A hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Stimulus and end of run. The random pairs come in runs of one flavor: wideband noise,
	// pairs in phase or out of phase (which drive the running mean and the width toward
	// their ends), pairs built from the rails, and quiet low-level signal.
	initial begin
		stim_mode_e  mode;
		int          run_left;
		logic [15:0] left_word;
		logic [15:0] right_word;
		mode = SPREAD_RANDOM;
		run_left = 0;
		for (int n = 0; n < DIRECTED_ITEMS; n++) begin
			pending_pairs[pend_wr] = pair_t'(directed_words[n]);
			pend_wr++;
		end
		for (int n = DIRECTED_ITEMS; n < TOTAL_ITEMS; n++) begin
			if (run_left == 0) begin
				mode = stim_mode_e'($urandom_range(4));
				run_left = $urandom_range(8, 64);
			end
			run_left--;
			left_word = 16'($urandom);
			case (mode)
				IN_PHASE: begin
					right_word = left_word ^ 16'($urandom_range(255));
				end
				OUT_OF_PHASE: begin
					right_word = (-left_word) ^ 16'($urandom_range(255));
				end
				RAIL_VALUES: begin
					left_word  = rail_values[$urandom_range(4)];
					right_word = rail_values[$urandom_range(4)];
				end
				QUIET: begin
					left_word  = 16'(int'($urandom_range(127)) - 64);
					right_word = 16'(int'($urandom_range(127)) - 64);
				end
				default: begin
					right_word = 16'($urandom);
				end
			endcase
			pending_pairs[pend_wr] = pair_t'({left_word, right_word});
			pend_wr++;
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (sent_count < TOTAL_ITEMS)
			@(posedge clk);
		while (exp_rd != exp_wr)
			@(posedge clk);
		// Any reading that shows up now has no pair behind it and is flagged by the monitor.
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (failures == 0 && exp_rd == exp_wr) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
